// ----- rtl/gfhf_pkg.sv -----
// Shared types, codes and constants of the GOOSE frame header filter.
package gfhf_pkg;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_TOO_SHORT  = 3'd1,
		ST_NOT_GOOSE  = 3'd2,
		ST_LEN_EXCEED = 3'd3,
		ST_MISMATCH   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_FILTER_APPID = 2'd0,
		REG_MATCH_ANY    = 2'd1,
		REG_FILTER_MAC   = 2'd2,
		REG_CHECK_MAC    = 2'd3
	} reg_idx_t;

	localparam logic [15:0] ETH_TPID      = 16'h8100;
	localparam logic [15:0] GOOSE_TYPE    = 16'h88B8;
	localparam int unsigned MIN_FRAME     = 22;
	localparam int unsigned HDR_UNTAGGED  = 14;
	localparam int unsigned HDR_TAGGED    = 18;
	localparam int unsigned APDU_HDR      = 8;

	typedef struct packed {
		logic [47:0] dst;
		logic        tag_seen;
		logic [15:0] tag_control;
		logic [15:0] type_word;
		logic [15:0] appid;
		logic [15:0] length;
	} hdr_t;

	typedef struct packed {
		logic [15:0] filter_appid;
		logic        match_any_appid;
		logic [47:0] filter_dst_mac;
		logic        check_dst_mac;
	} cfg_t;

	function automatic logic [15:0] put_byte(logic [15:0] word, logic [7:0] b, logic high);
		logic [15:0] r;
		r = high ? {b, word[7:0]} : {word[15:8], b};
		return r;
	endfunction

endpackage

// ----- rtl/gfhf_if.sv -----
// Channel interfaces: frame bytes, verdicts and configuration writes.
interface gfhf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gfhf_verdict_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [47:0]        dst_address;
	logic               vlan_present;
	logic [11:0]        vlan_number;
	logic [2:0]         vlan_priority;
	logic [15:0]        application_id;
	logic [15:0]        length_field;
	logic signed [16:0] apdu_length;
	logic [4:0]         apdu_offset;
	modport source (output valid, output status, output dst_address, output vlan_present,
		output vlan_number, output vlan_priority, output application_id,
		output length_field, output apdu_length, output apdu_offset, input ready);
	modport sink (input valid, input status, input dst_address, input vlan_present,
		input vlan_number, input vlan_priority, input application_id,
		input length_field, input apdu_length, input apdu_offset, output ready);
endinterface

interface gfhf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [47:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gfhf_check.sv -----
// Verdict logic: ordered header, length and filter checks at the last byte.
module gfhf_check
	import gfhf_pkg::*;
#(
	parameter int POSITION_BITS = 11
) (
	input  hdr_t                   hdr,
	input  cfg_t                   cfg,
	input  logic [POSITION_BITS:0] n,
	output status_t                status
);
	localparam int NB = POSITION_BITS + 1;

	logic [17:0] n_w;
	logic [17:0] need_w;
	logic [4:0]  hdr_len;
	logic        appid_ok;
	logic        mac_ok;

	always_comb begin
		hdr_len  = hdr.tag_seen ? 5'(HDR_TAGGED) : 5'(HDR_UNTAGGED);
		n_w      = 18'(n);
		need_w   = 18'(hdr.length) + 18'(hdr_len);
		appid_ok = cfg.match_any_appid || (hdr.appid == cfg.filter_appid);
		mac_ok   = !cfg.check_dst_mac || (hdr.dst == cfg.filter_dst_mac);
		if (n < NB'(MIN_FRAME)) begin
			status = ST_TOO_SHORT;
		end else if (hdr.type_word != GOOSE_TYPE) begin
			status = ST_NOT_GOOSE;
		end else if (n_w < 18'(hdr_len) + 18'(APDU_HDR)) begin
			status = ST_TOO_SHORT;
		end else if (n_w < need_w) begin
			status = ST_LEN_EXCEED;
		end else if (!appid_ok || !mac_ok) begin
			status = ST_MISMATCH;
		end else begin
			status = ST_ACCEPTED;
		end
	end
endmodule

// ----- rtl/goose_frame_header_filter.sv -----
// Top level of the GOOSE frame header filter.
// Frame bytes enter through a one-entry input register and are folded into the
// header capture one per clock, one byte per cycle sustained while no last byte
// waits on a stalled verdict. The frame's last byte loads one verdict into the
// output register as it leaves the input register; a stalled verdict holds the
// input side only when the next last byte arrives. Configuration writes are always ready.
module goose_frame_header_filter
	import gfhf_pkg::*;
#(
	parameter int POSITION_BITS = 11
) (
	input logic                 clk,
	input logic                 arst_n,
	gfhf_byte_if.sink           frame,
	gfhf_verdict_if.source      verdict,
	gfhf_cfg_if.sink            cfg
);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [POSITION_BITS-1:0] POS_6   = POSITION_BITS'(6);
	localparam logic [POSITION_BITS-1:0] POS_12  = POSITION_BITS'(12);
	localparam logic [POSITION_BITS-1:0] POS_13  = POSITION_BITS'(13);
	localparam logic [POSITION_BITS-1:0] POS_14  = POSITION_BITS'(14);
	localparam logic [POSITION_BITS-1:0] POS_21  = POSITION_BITS'(21);

	cfg_t                     cfg_q;
	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic [POSITION_BITS-1:0] pos_q;
	hdr_t                     hdr_q;
	hdr_t                     hdr_d;
	logic                     advance;
	logic                     load;
	logic [POSITION_BITS:0]   n;
	status_t                  status_d;
	logic [2:0]               dst_idx;
	logic [2:0]               rel;
	logic                     high;
	logic                     out_valid_q;

	// Configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_appid    <= '0;
			cfg_q.match_any_appid <= 1'b1;
			cfg_q.filter_dst_mac  <= '0;
			cfg_q.check_dst_mac   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_FILTER_APPID: cfg_q.filter_appid    <= cfg.data[15:0];
				REG_MATCH_ANY:    cfg_q.match_any_appid <= cfg.data[0];
				REG_FILTER_MAC:   cfg_q.filter_dst_mac  <= cfg.data;
				REG_CHECK_MAC:    cfg_q.check_dst_mac   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign load        = advance && last_s1;
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			byte_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// Header capture
	always_comb begin
		hdr_d   = hdr_q;
		dst_idx = 3'd5 - pos_q[2:0];
		rel     = pos_q[2:0] - 3'd6;
		high    = !rel[0];
		if (pos_q < POS_6) begin
			hdr_d.dst[{dst_idx, 3'b000} +: 8] = byte_s1;
		end else if (pos_q == POS_12) begin
			hdr_d.type_word[15:8] = byte_s1;
		end else if (pos_q == POS_13) begin
			hdr_d.type_word[7:0] = byte_s1;
			hdr_d.tag_seen       = ({hdr_q.type_word[15:8], byte_s1} == ETH_TPID);
		end else if (pos_q >= POS_14 && pos_q <= POS_21) begin
			if (hdr_q.tag_seen) begin
				case (rel[2:1])
					2'd0: hdr_d.tag_control = put_byte(hdr_q.tag_control, byte_s1, high);
					2'd1: hdr_d.type_word   = put_byte(hdr_q.type_word, byte_s1, high);
					2'd2: hdr_d.appid       = put_byte(hdr_q.appid, byte_s1, high);
					default: hdr_d.length   = put_byte(hdr_q.length, byte_s1, high);
				endcase
			end else begin
				case (rel[2:1])
					2'd0: hdr_d.appid  = put_byte(hdr_q.appid, byte_s1, high);
					2'd1: hdr_d.length = put_byte(hdr_q.length, byte_s1, high);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				hdr_q <= '0;
			end else begin
				hdr_q <= hdr_d;
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign n = {1'b0, pos_q} + 1'b1;

	gfhf_check #(
		.POSITION_BITS(POSITION_BITS)
	) u_check (
		.hdr    (hdr_d),
		.cfg    (cfg_q),
		.n      (n),
		.status (status_d)
	);

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict.status         <= status_d;
			verdict.dst_address    <= hdr_d.dst;
			verdict.vlan_present   <= hdr_d.tag_seen;
			verdict.vlan_number    <= hdr_d.tag_seen ? hdr_d.tag_control[11:0] : 12'd0;
			verdict.vlan_priority  <= hdr_d.tag_seen ? hdr_d.tag_control[15:13] : 3'd0;
			verdict.application_id <= hdr_d.appid;
			verdict.length_field   <= hdr_d.length;
			verdict.apdu_length    <= $signed({1'b0, hdr_d.length} - 17'(APDU_HDR));
			verdict.apdu_offset    <= hdr_d.tag_seen ? 5'(HDR_TAGGED + APDU_HDR)
				: 5'(HDR_UNTAGGED + APDU_HDR);
		end
	end

	assign verdict.valid = out_valid_q;

	// Checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || verdict.ready))
		else $error("verdict loaded over an untaken one");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (pos_q == '0 && hdr_q == '0))
		else $error("frame state not cleared after last byte");

	a_untagged_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !verdict.vlan_present) |->
		(verdict.vlan_number == 12'd0 && verdict.vlan_priority == 3'd0 &&
		verdict.apdu_offset == 5'(HDR_UNTAGGED + APDU_HDR)))
		else $error("untagged verdict carries tag fields");

	a_accept_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(load && status_d == ST_ACCEPTED) |->
		((cfg_q.match_any_appid || hdr_d.appid == cfg_q.filter_appid) &&
		hdr_d.type_word == GOOSE_TYPE))
		else $error("frame accepted against the filter");
endmodule

// ----- tb/tb_goose_frame_header_filter.sv -----
// Self-checking testbench for the GOOSE frame header filter: directed frames, then random traffic.
module tb_goose_frame_header_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import gfhf_pkg::*;

	localparam int POS_BITS = 11;
	localparam logic [POS_BITS-1:0] POS_FULL = '1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_BYTES = 200;
	localparam int RANDOM_PHASES = 6;

	typedef struct packed {
		status_t     status;
		logic [47:0] dst;
		logic        vlan;
		logic [11:0] vid;
		logic [2:0]  pcp;
		logic [15:0] appid;
		logic [15:0] len;
		logic [16:0] apdu_len;
		logic [4:0]  apdu_off;
	} verdict_t;

	typedef struct packed {
		int          phase;
		logic [47:0] dst;
		bit          has_tag;
		logic [15:0] tci;
		logic [15:0] etype;
		logic [15:0] appid;
		logic [15:0] lenf;
		int          nbytes;
		bit          known;
		status_t     st;
	} frame_row_t;

	localparam frame_row_t PLAN [23] = '{
		'{0, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0001, 16'h0008, 1, 1'b1, ST_TOO_SHORT},
		'{0, 48'h0102_0304_0506, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0001, 16'h0008, 21, 1'b1,
			ST_TOO_SHORT},
		'{0, 48'h0102_0304_0506, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0001, 16'h0008, 22, 1'b1,
			ST_ACCEPTED},
		'{0, 48'h0102_0304_0506, 1'b0, 16'h0000, 16'h88B9, 16'h0001, 16'h0008, 22, 1'b1,
			ST_NOT_GOOSE},
		'{0, 48'h0102_0304_0506, 1'b1, 16'h1234, GOOSE_TYPE, 16'h0001, 16'h0008, 22, 1'b1,
			ST_TOO_SHORT},
		'{0, 48'h0102_0304_0506, 1'b1, 16'h1234, GOOSE_TYPE, 16'h0001, 16'h0008, 25, 1'b1,
			ST_TOO_SHORT},
		'{0, 48'hA5A5_5A5A_A5A5, 1'b1, 16'hFFFF, GOOSE_TYPE, 16'hFFFF, 16'h0008, 26, 1'b1,
			ST_ACCEPTED},
		'{0, 48'hA5A5_5A5A_A5A5, 1'b1, 16'hFFFF, GOOSE_TYPE, 16'hFFFF, 16'h0009, 26, 1'b1,
			ST_LEN_EXCEED},
		'{0, 48'h0000_0000_0001, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'h0000, 30, 1'b1,
			ST_ACCEPTED},
		'{0, 48'h0000_0000_0001, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'hFFFF, 30, 1'b1,
			ST_LEN_EXCEED},
		'{0, 48'h0000_0000_0001, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'h0010, 30, 1'b1,
			ST_ACCEPTED},
		'{0, 48'h0000_0000_0001, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'h0011, 30, 1'b1,
			ST_LEN_EXCEED},
		'{0, 48'h0102_0304_0506, 1'b1, 16'h5555, ETH_TPID, 16'h0001, 16'h0008, 30, 1'b1,
			ST_NOT_GOOSE},
		'{0, 48'h0000_0000_0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 22, 1'b1,
			ST_NOT_GOOSE},
		'{0, 48'h0102_0304_0506, 1'b1, 16'h1234, GOOSE_TYPE, 16'h0001, 16'h0008, 12, 1'b1,
			ST_TOO_SHORT},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000, GOOSE_TYPE, 16'hFFFF, 16'd20, 40, 1'b1,
			ST_ACCEPTED},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000, GOOSE_TYPE, 16'hFFFE, 16'd20, 40, 1'b1,
			ST_MISMATCH},
		'{1, 48'hFFFF_FFFF_FFFE, 1'b0, 16'h0000, GOOSE_TYPE, 16'hFFFF, 16'd20, 40, 1'b1,
			ST_MISMATCH},
		'{1, 48'h0000_0000_0000, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'd8, 21, 1'b1,
			ST_TOO_SHORT},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000, 16'h88B7, 16'h0000, 16'd8, 40, 1'b1,
			ST_NOT_GOOSE},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000, GOOSE_TYPE, 16'h0000, 16'd30, 40, 1'b1,
			ST_LEN_EXCEED},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b1, 16'h0000, GOOSE_TYPE, 16'hFFFF, 16'd12, 30, 1'b1,
			ST_ACCEPTED},
		'{1, 48'hFFFF_FFFF_FFFF, 1'b1, 16'h2ABC, GOOSE_TYPE, 16'h0000, 16'd8, 26, 1'b0,
			ST_ACCEPTED}
	};

	logic clk;
	logic arst_n;

	gfhf_byte_if    frame_if ();
	gfhf_verdict_if verdict_if ();
	gfhf_cfg_if     cfg_if ();

	goose_frame_header_filter #(.POSITION_BITS(POS_BITS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_if),
		.verdict (verdict_if),
		.cfg     (cfg_if)
	);

	// header capture and filter settings as the block should hold them
	hdr_t                cap = '0;
	logic [POS_BITS-1:0] pos = '0;
	cfg_t                filt = '{16'h0000, 1'b1, 48'h0, 1'b0};

	verdict_t verdict_q [$];

	int  errors = 0;
	int  bytes_sent = 0;
	int  frames_sent = 0;
	int  verdicts_seen = 0;
	int  cfg_writes = 0;
	int  settings_used = 1;
	int  sink_wait = 0;
	int  cycle_count = 0;
	bit  src_quiet = 1'b0;
	bit  sink_quiet = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int draw_gap(input bit quiet);
		if (quiet || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 16);
	endfunction

	function automatic bit fold_byte(input logic [7:0] b, input logic l, output verdict_t v);
		int p;
		int n;
		int hl;
		int rel;
		int lo;
		status_t st;
		p = int'(pos);
		v = '0;
		if (p < 6) begin
			cap.dst[8*(5-p) +: 8] = b;
		end else if (p == 12) begin
			cap.type_word[15:8] = b;
		end else if (p == 13) begin
			cap.type_word[7:0] = b;
			cap.tag_seen = (cap.type_word == ETH_TPID);
		end else if (p >= 14 && p <= 21) begin
			rel = p - 14;
			lo = (rel % 2) ? 0 : 8;
			if (cap.tag_seen) begin
				case (rel / 2)
					0: cap.tag_control[lo +: 8] = b;
					1: cap.type_word[lo +: 8] = b;
					2: cap.appid[lo +: 8] = b;
					default: cap.length[lo +: 8] = b;
				endcase
			end else if (rel < 2) begin
				cap.appid[lo +: 8] = b;
			end else if (rel < 4) begin
				cap.length[lo +: 8] = b;
			end
		end
		if (!l) begin
			if (pos != POS_FULL)
				pos++;
			return 1'b0;
		end
		n = p + 1;
		hl = cap.tag_seen ? HDR_TAGGED : HDR_UNTAGGED;
		if (n < MIN_FRAME)
			st = ST_TOO_SHORT;
		else if (cap.type_word != GOOSE_TYPE)
			st = ST_NOT_GOOSE;
		else if (n < hl + APDU_HDR)
			st = ST_TOO_SHORT;
		else if (n < int'(cap.length) + hl)
			st = ST_LEN_EXCEED;
		else if ((!filt.match_any_appid && cap.appid != filt.filter_appid) ||
				(filt.check_dst_mac && cap.dst != filt.filter_dst_mac))
			st = ST_MISMATCH;
		else
			st = ST_ACCEPTED;
		v.status = st;
		v.dst = cap.dst;
		v.vlan = cap.tag_seen;
		v.vid = cap.tag_seen ? cap.tag_control[11:0] : 12'h000;
		v.pcp = cap.tag_seen ? cap.tag_control[15:13] : 3'h0;
		v.appid = cap.appid;
		v.len = cap.length;
		v.apdu_len = {1'b0, cap.length} - 17'(APDU_HDR);
		v.apdu_off = 5'(hl + APDU_HDR);
		cap = '0;
		pos = '0;
		return 1'b1;
	endfunction

	function automatic cfg_t phase_cfg(input int ph);
		cfg_t c;
		c.filter_appid = 16'($urandom);
		c.match_any_appid = 1'($urandom_range(0, 1));
		c.filter_dst_mac = 48'({$urandom(), $urandom()});
		c.check_dst_mac = 1'($urandom_range(0, 1));
		case (ph)
			0: c = '{16'h0000, 1'b1, 48'h0, 1'b0};
			1: c = '{16'h0000, 1'b0, 48'h0, 1'b1};
			2: c = '{16'hFFFF, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1};
			default: ;
		endcase
		return c;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic check_verdict(input verdict_t e);
		check_field("status", e.status, verdict_if.status);
		check_field("dst_address", e.dst, verdict_if.dst_address);
		check_field("vlan_present", e.vlan, verdict_if.vlan_present);
		check_field("vlan_number", e.vid, verdict_if.vlan_number);
		check_field("vlan_priority", e.pcp, verdict_if.vlan_priority);
		check_field("application_id", e.appid, verdict_if.application_id);
		check_field("length_field", e.len, verdict_if.length_field);
		check_field("apdu_length", longint'($signed(e.apdu_len)),
			longint'(verdict_if.apdu_length));
		check_field("apdu_offset", e.apdu_off, verdict_if.apdu_offset);
	endtask

	// called at a falling edge; leaves valid high so back-to-back bytes need no re-raise
	task automatic push_byte(input logic [7:0] b, input logic l, input int known);
		int gap;
		verdict_t v;
		gap = draw_gap(src_quiet);
		if (gap > 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_if.valid <= 1'b1;
		frame_if.data_byte <= b;
		frame_if.last_byte <= l;
		do @(posedge clk); while (!frame_if.ready);
		bytes_sent++;
		if (fold_byte(b, l, v)) begin
			if (known >= 0)
				v.status = status_t'(known);
			verdict_q.push_back(v);
		end
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [47:0] dst, input bit has_tag, input logic [15:0] tci,
			input logic [15:0] etype, input logic [15:0] appid, input logic [15:0] lenf,
			input int nbytes, input int known);
		logic [7:0] hb [26];
		logic [7:0] b;
		for (int i = 0; i < 26; i++)
			hb[i] = 8'($urandom);
		for (int i = 0; i < 6; i++)
			hb[i] = dst[8*(5-i) +: 8];
		if (has_tag) begin
			{hb[12], hb[13]} = ETH_TPID;
			{hb[14], hb[15]} = tci;
			{hb[16], hb[17]} = etype;
			{hb[18], hb[19]} = appid;
			{hb[20], hb[21]} = lenf;
		end else begin
			{hb[12], hb[13]} = etype;
			{hb[14], hb[15]} = appid;
			{hb[16], hb[17]} = lenf;
		end
		for (int i = 0; i < nbytes; i++) begin
			b = (i < 26) ? hb[i] : 8'($urandom);
			push_byte(b, i == nbytes - 1, known);
		end
		frames_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [47:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= d;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_FILTER_APPID: filt.filter_appid = d[15:0];
			REG_MATCH_ANY:    filt.match_any_appid = d[0];
			REG_FILTER_MAC:   filt.filter_dst_mac = d;
			REG_CHECK_MAC:    filt.check_dst_mac = d[0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// only once the filter has drained
	task automatic apply_config(input cfg_t c);
		frame_if.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_FILTER_APPID, 48'(c.filter_appid));
		write_reg(REG_MATCH_ANY, 48'(c.match_any_appid));
		write_reg(REG_FILTER_MAC, c.filter_dst_mac);
		write_reg(REG_CHECK_MAC, 48'(c.check_dst_mac));
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic random_frame();
		int kind;
		int plen;
		int hl;
		int nb;
		bit tg;
		logic [47:0] dst;
		logic [15:0] appid;
		logic [15:0] lenf;
		logic [15:0] etype;
		if ($urandom_range(0, 5) == 0)
			src_quiet = !src_quiet;
		if ($urandom_range(0, 5) == 0)
			sink_quiet = !sink_quiet;
		kind = $urandom_range(0, 9);
		tg = 1'($urandom_range(0, 1));
		hl = tg ? HDR_TAGGED : HDR_UNTAGGED;
		dst = ($urandom_range(0, 3) != 0) ? filt.filter_dst_mac : 48'({$urandom(), $urandom()});
		appid = ($urandom_range(0, 3) != 0) ? filt.filter_appid : 16'($urandom);
		plen = $urandom_range(0, 24);
		nb = hl + APDU_HDR + plen;
		lenf = 16'($urandom_range(0, APDU_HDR + plen));
		etype = GOOSE_TYPE;
		case (kind)
			6: nb = $urandom_range(1, hl + 7);
			7: etype = 16'($urandom);
			8: begin
				// noise
				nb = $urandom_range(1, 40);
				dst = 48'({$urandom(), $urandom()});
				appid = 16'($urandom);
				lenf = 16'($urandom);
				if ($urandom_range(0, 1) != 0)
					etype = 16'($urandom);
			end
			9: lenf = ($urandom_range(0, 1) != 0) ? 16'($urandom) :
				16'(APDU_HDR + plen + $urandom_range(1, 4));
			default: ;
		endcase
		send_frame(dst, tg, 16'($urandom), etype, appid, lenf, nb, -1);
	endtask

	// verdict receiver: stall drawn after each transfer
	always @(negedge clk) begin
		if (sink_wait > 0) begin
			verdict_if.ready <= 1'b0;
			sink_wait--;
		end else begin
			verdict_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (verdict_if.valid && verdict_if.ready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict transfer with none expected, status %0d", verdict_if.status);
				errors++;
			end else begin
				check_verdict(verdict_q.pop_front());
			end
			verdicts_seen++;
			sink_wait = draw_gap(sink_quiet);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
			verdict_q.size());
		$display("** goose_frame_header_filter: FAILED **");
		$finish;
	end

	initial begin
		int cur_phase;
		int start_bytes;
		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		frame_if.data_byte = 8'h00;
		frame_if.last_byte = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_FILTER_APPID;
		cfg_if.data = 48'h0;
		cur_phase = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (PLAN[k]) begin
			if (PLAN[k].phase != cur_phase) begin
				apply_config('{16'hFFFF, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1});
				cur_phase = PLAN[k].phase;
			end
			send_frame(PLAN[k].dst, PLAN[k].has_tag, PLAN[k].tci, PLAN[k].etype, PLAN[k].appid,
				PLAN[k].lenf, PLAN[k].nbytes, PLAN[k].known ? int'(PLAN[k].st) : -1);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_config(phase_cfg(ph));
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < PHASE_BYTES)
				random_frame();
		end

		frame_if.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d frames (%0d bytes) under %0d filter settings, %0d register writes;",
			frames_sent, bytes_sent, settings_used, cfg_writes);
		$display("checked %0d verdicts, %0d field mismatches.", verdicts_seen, errors);
		if (errors == 0)
			$display("** goose_frame_header_filter: PASSED **");
		else
			$display("** goose_frame_header_filter: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/gfhf_pkg.sv
rtl/gfhf_if.sv
rtl/gfhf_check.sv
rtl/goose_frame_header_filter.sv
tb/tb_goose_frame_header_filter.sv
